FILE: hdl/fir_filter_67_tap_core_defines.svh
// Assertion macros for the FIR filter RTL, included by the sequencer.
// Expects signals named aclk and aresetn in the including module.
`ifndef FIR_FILTER_67_TAP_CORE_DEFINES_SVH
`define FIR_FILTER_67_TAP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FIR67_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fir67: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FIR67_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fir67: next-cycle check failed");

`endif

FILE: hdl/fir67_pkg.sv
// Shared types, sizes and the coefficient ROM of the 67-tap FIR filter.
// Depends on nothing; every RTL module refers to it by scoped names.
`default_nettype none

package fir67_pkg;

    localparam int TAPS         = 67;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int ACC_WIDTH    = 40;
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ADDR_WIDTH   = $clog2(TAPS);
    localparam int FRAC_BITS    = COEF_WIDTH - 1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic signed [ACC_WIDTH-1:0]    acc_t;
    typedef logic        [ADDR_WIDTH-1:0]   addr_t;

    // Control from the sequencer to the delay-line memory.
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        logic  rd_en;
        addr_t rd_addr;
    } ram_ctrl_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic  clear;
        logic  load;
        addr_t tap;
        logic  mul_en;
        logic  acc_en;
    } mac_ctrl_t;

    localparam coef_t COEF_ROM [TAPS] = '{
        16'sd48, 16'sd47, 16'sd54, 16'sd44, 16'sd12,
        -16'sd45, -16'sd122, -16'sd209, -16'sd286, -16'sd330,
        -16'sd319, -16'sd236, -16'sd77, 16'sd149, 16'sd411,
        16'sd667, 16'sd865, 16'sd952, 16'sd890, 16'sd663,
        16'sd284, -16'sd205, -16'sd732, -16'sd1209, -16'sd1549,
        -16'sd1680, -16'sd1559, -16'sd1186, -16'sd606, 16'sd100,
        16'sd822, 16'sd1444, 16'sd1864, 16'sd2013, 16'sd1864,
        16'sd1444, 16'sd822, 16'sd100, -16'sd606, -16'sd1186,
        -16'sd1559, -16'sd1680, -16'sd1549, -16'sd1209, -16'sd732,
        -16'sd205, 16'sd284, 16'sd663, 16'sd890, 16'sd952,
        16'sd865, 16'sd667, 16'sd411, 16'sd149, -16'sd77,
        -16'sd236, -16'sd319, -16'sd330, -16'sd286, -16'sd209,
        -16'sd122, -16'sd45, 16'sd12, 16'sd44, 16'sd54,
        16'sd47, 16'sd48
    };

    // Coefficient of one tap; indices beyond the table read as zero.
    function automatic coef_t coef_at(addr_t idx);
        coef_t c;
        c = '0;
        if (int'(idx) < TAPS) begin
            c = COEF_ROM[idx];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fir67_tap_ram.sv
// Delay-line memory of the FIR filter: one write and one registered read port.
// Per-entry valid bits make unwritten slots read as zero. Uses fir67_pkg.
`default_nettype none

module fir67_tap_ram (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fir67_pkg::ram_ctrl_t  ctrl,
    input  wire fir67_pkg::sample_t    wr_data,
    output fir67_pkg::sample_t         rd_data
);

    fir67_pkg::sample_t          mem [fir67_pkg::TAPS];
    logic [fir67_pkg::TAPS-1:0]  valid_reg;
    fir67_pkg::sample_t          rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.wr_en) begin
            valid_reg[ctrl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= valid_reg[ctrl.rd_addr] ? mem[ctrl.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/fir67_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// Uses fir67_pkg for types and the coefficient ROM.
`default_nettype none

module fir67_mac (
    input  wire logic                  aclk,
    input  wire fir67_pkg::mac_ctrl_t  ctrl,
    input  wire fir67_pkg::sample_t    tap_data,
    output fir67_pkg::sample_t         result
);

    localparam int RND_WIDTH = fir67_pkg::ACC_WIDTH + 1;

    fir67_pkg::coef_t coef_reg;
    fir67_pkg::prod_t prod_reg;
    fir67_pkg::acc_t  acc_reg;
    fir67_pkg::acc_t  acc_next;

    logic signed [RND_WIDTH-1:0] rounded;
    logic signed [RND_WIDTH-1:0] shifted;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            coef_reg <= fir67_pkg::coef_at(ctrl.tap);
        end
        if (ctrl.mul_en) begin
            prod_reg <= tap_data * coef_reg;
        end
        acc_reg <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.acc_en) begin
            acc_next = acc_reg + fir67_pkg::acc_t'(prod_reg);
        end
    end

    // Round half up, then saturate to the sample range.
    always_comb begin
        rounded = RND_WIDTH'(acc_reg) + (RND_WIDTH'(1) <<< (fir67_pkg::FRAC_BITS - 1));
        shifted = rounded >>> fir67_pkg::FRAC_BITS;
        if (shifted > $signed({{(RND_WIDTH-fir67_pkg::SAMPLE_WIDTH+1){1'b0}},
                              {(fir67_pkg::SAMPLE_WIDTH-1){1'b1}}})) begin
            result = {1'b0, {(fir67_pkg::SAMPLE_WIDTH-1){1'b1}}};
        end else if (shifted < $signed({{(RND_WIDTH-fir67_pkg::SAMPLE_WIDTH+1){1'b1}},
                                        {(fir67_pkg::SAMPLE_WIDTH-1){1'b0}}})) begin
            result = {1'b1, {(fir67_pkg::SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            result = shifted[fir67_pkg::SAMPLE_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fir67_seq.sv
// Sequencer of the FIR filter: handshake, write pointer, tap walk and pipeline tracking.
// Uses fir67_pkg and the assertion macros of fir_filter_67_tap_core_defines.svh.
`default_nettype none
`include "fir_filter_67_tap_core_defines.svh"

module fir67_seq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    output fir67_pkg::ram_ctrl_t       ram_ctrl,
    output fir67_pkg::mac_ctrl_t       mac_ctrl,
    output logic                       out_load
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam fir67_pkg::addr_t LAST = fir67_pkg::addr_t'(fir67_pkg::TAPS - 1);

    logic [1:0]       state_reg, state_next;
    fir67_pkg::addr_t wr_pos_reg, wr_pos_next;
    fir67_pkg::addr_t rd_pos_reg, rd_pos_next;
    fir67_pkg::addr_t tap_reg, tap_next;
    logic             rd_v_reg, prod_v_reg;
    logic             in_fire, issue;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign issue    = (state_reg == ST_RUN);
    assign out_load = (state_reg == ST_OUT) && (!m_valid || m_ready);

    always_comb begin
        state_next  = state_reg;
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        tap_next    = tap_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    rd_pos_next = wr_pos_reg;
                    tap_next    = '0;
                    wr_pos_next = (wr_pos_reg == LAST) ? '0 : wr_pos_reg + 1'b1;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                rd_pos_next = (rd_pos_reg == '0) ? LAST : rd_pos_reg - 1'b1;
                tap_next    = tap_reg + 1'b1;
                if (tap_reg == LAST) begin
                    tap_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !prod_v_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            tap_reg    <= '0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            tap_reg    <= tap_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
        end
    end

    always_comb begin
        ram_ctrl.wr_en   = in_fire;
        ram_ctrl.wr_addr = wr_pos_reg;
        ram_ctrl.rd_en   = issue;
        ram_ctrl.rd_addr = rd_pos_reg;
        mac_ctrl.clear   = in_fire;
        mac_ctrl.load    = issue;
        mac_ctrl.tap     = tap_reg;
        mac_ctrl.mul_en  = rd_v_reg;
        mac_ctrl.acc_en  = prod_v_reg;
    end

    `FIR67_ASSERT_IMP(a_out_after_drain, out_load, !rd_v_reg && !prod_v_reg && !issue)
    `FIR67_ASSERT_NXT(a_accept_starts_walk, in_fire, (state_reg == ST_RUN) && (tap_reg == '0))
    `FIR67_ASSERT_NXT(a_read_tracked, issue, rd_v_reg)
    `FIR67_ASSERT_IMP(a_ptr_in_range, 1'b1, (wr_pos_reg <= LAST) && (rd_pos_reg <= LAST))

endmodule

`default_nettype wire

FILE: hdl/fir_filter_67_tap_core.sv
// An input transaction is accepted only in idle; the 67 taps then pass one by one through
// the single shared multiply-accumulate unit, the read and multiply stages drain, the
// rounded sum is loaded into the output register, raising m_valid, once no earlier result
// still waits there, and the sequencer returns to idle before it takes the next sample.
// aresetn (synchronous, active low) empties the delay line through its valid bits, sets
// the write position to slot zero and drops m_valid; no clearing pass.
`default_nettype none

module fir_filter_67_tap_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire fir67_pkg::sample_t  s_sample_in,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output fir67_pkg::sample_t       m_sample_out
);

    // The sequencer steers the delay-line memory and the multiply-accumulate unit.
    // Each accepted transaction writes its sample at the write position, after which
    // the taps are read newest first, one per cycle, while the tap index walks the ROM.
    fir67_pkg::ram_ctrl_t ram_ctrl;
    fir67_pkg::mac_ctrl_t mac_ctrl;
    fir67_pkg::sample_t   tap_data;
    fir67_pkg::sample_t   result;
    logic                 out_load;

    // The output register parts the two sides: a finished result waits here for the
    // downstream transaction, and the sequencer only holds back when a second result
    // is ready before the first has been taken.
    logic                 m_valid_reg;
    fir67_pkg::sample_t   m_sample_out_reg;

    fir67_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid_reg),
        .m_ready  (m_ready),
        .ram_ctrl (ram_ctrl),
        .mac_ctrl (mac_ctrl),
        .out_load (out_load)
    );

    fir67_tap_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ram_ctrl),
        .wr_data (s_sample_in),
        .rd_data (tap_data)
    );

    fir67_mac u_mac (
        .aclk     (aclk),
        .ctrl     (mac_ctrl),
        .tap_data (tap_data),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // The payload register needs no reset; it is only looked at while m_valid is high.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sample_out_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the 67-tap FIR filter core, fir_filter_67_tap_core.
// Depends on fir67_pkg for the port types; the expected samples come from a
// behavioural filter kept in this file.

module tb;

    localparam int NUM_TAPS     = 67;
    localparam int SAMPLE_COUNT = 1050;
    // The core's computation time, plus the longest sender gap and
    // receiver stall, for every sample, and then several times that again.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 100;

    // Filter coefficients in signed Q1.15, newest sample first.
    localparam fir67_pkg::coef_t LOWPASS_TAPS [NUM_TAPS] = '{
        48, 47, 54, 44, 12, -45, -122, -209, -286, -330,
        -319, -236, -77, 149, 411, 667, 865, 952, 890, 663,
        284, -205, -732, -1209, -1549, -1680, -1559, -1186, -606, 100,
        822, 1444, 1864, 2013, 1864, 1444, 822, 100, -606, -1186,
        -1559, -1680, -1549, -1209, -732, -205, 284, 663, 890, 952,
        865, 667, 411, 149, -77, -236, -319, -330, -286, -209,
        -122, -45, 12, 44, 54, 47, 48
    };

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    fir67_pkg::sample_t s_sample_in  = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    fir67_pkg::sample_t m_sample_out;

    // Samples waiting to be offered, and filter outputs still owed by the core.
    fir67_pkg::sample_t pending_samples [$];
    fir67_pkg::sample_t expected_outputs [$];

    // Behavioural copy of the delay line and the slot that takes the next sample.
    fir67_pkg::sample_t history [NUM_TAPS];
    int                 history_slot = 0;

    int accepted_count = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    // Sender burst and gap bookkeeping, and the receiver's stall pattern.
    int                 burst_left = 1;
    int                 gap_left   = 0;
    int                 stall_left = 0;
    int                 open_left  = 0;
    fir67_pkg::sample_t oldest_expected;

    always #10 aclk = ~aclk;

    fir_filter_67_tap_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    // Pushes one sample into the behavioural delay line and returns the filtered
    // value. The sum is kept in a 40-bit accumulator, which wraps as the hardware
    // does; half an LSB is then added, the sum is shifted down arithmetically by
    // 15 bits and the result is clamped to the 16-bit signed range.
    function automatic fir67_pkg::sample_t filter_sample(fir67_pkg::sample_t x);
        fir67_pkg::acc_t acc;
        int              slot;
        int              j;
        longint          y;
        history[history_slot] = x;
        acc  = '0;
        slot = history_slot;
        for (j = 0; j < NUM_TAPS; j++) begin
            acc  = acc + fir67_pkg::acc_t'(LOWPASS_TAPS[j]) *
                         fir67_pkg::acc_t'(history[slot]);
            slot = (slot == 0) ? NUM_TAPS - 1 : slot - 1;
        end
        history_slot = (history_slot == NUM_TAPS - 1) ? 0 : history_slot + 1;
        y = (longint'(acc) + 64'sd16384) >>> 15;
        if (y > 32767) begin
            y = 32767;
        end
        if (y < -32768) begin
            y = -32768;
        end
        return fir67_pkg::sample_t'(y);
    endfunction

    // Driver. A new sample is only presented once the previous transaction has
    // been accepted, so valid and the payload stay put while the core is busy.
    // The prediction is made at the accepting edge, which keeps the expected
    // queue in step with what the core really took.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_outputs.push_back(filter_sample(s_sample_in));
                accepted_count++;
            end
            if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else if (pending_samples.size() != 0) begin
                s_valid     <= 1'b1;
                s_sample_in <= pending_samples.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // One burst in three runs straight into the next one; the
                    // others leave gaps of widely varying length so that the next
                    // sample lands on every phase of the core's computation.
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                                 $urandom_range(1, $urandom_range(1, 150));
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every accepted output transaction is matched against the oldest
    // outstanding prediction. The ready pattern alternates open windows, some of
    // them long, with stalls that are either short or long enough to back up the
    // input side as well.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    $error("sample_out: transaction with nothing expected, actual %0d",
                           m_sample_out);
                    fail_count++;
                end else begin
                    oldest_expected = expected_outputs.pop_front();
                    if (m_sample_out !== oldest_expected) begin
                        $error("sample_out: expected %0d, actual %0d",
                               oldest_expected, m_sample_out);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (open_left > 0) begin
                    open_left--;
                end else begin
                    open_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 800) :
                                 $urandom_range(0, 60);
                    stall_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) :
                                 $urandom_range(1, 120);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and end of test. The whole sample stream is built up front and the
    // driver works through it; there are no configuration registers, so there is
    // no need to split the run into phases.
    initial begin
        int                 kind;
        int                 run_len;
        int                 j;
        int                 amp;
        fir67_pkg::sample_t level;

        for (j = 0; j < NUM_TAPS; j++) begin
            history[j] = '0;
        end

        // Directed opening. The first samples meet a cleared delay line, so the
        // taps reaching back before the start of the stream must count as zero.
        pending_samples.push_back(16'sd0);
        pending_samples.push_back(16'sd32767);
        pending_samples.push_back(-16'sd32768);
        pending_samples.push_back(16'sd1);
        pending_samples.push_back(-16'sd1);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(fir67_pkg::sample_t'(16'haaaa));
        for (j = 0; j < 4; j++) begin
            pending_samples.push_back(16'sd32767);
        end
        for (j = 0; j < 4; j++) begin
            pending_samples.push_back(-16'sd32768);
        end
        for (j = 0; j < 4; j++) begin
            pending_samples.push_back(16'sd0);
        end
        pending_samples.push_back(16'sd32767);
        pending_samples.push_back(-16'sd32768);
        pending_samples.push_back(16'sd32767);
        pending_samples.push_back(16'sd0);

        // Random part, built from runs of different character. The runs matched
        // to the coefficient signs drive the accumulator past full scale, so
        // both saturation limits are hit; the small and impulse runs exercise the
        // rounding of values close to zero.
        while (pending_samples.size() < SAMPLE_COUNT) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    amp = ($urandom_range(0, 1) == 0) ? 32767 : $urandom_range(500, 32767);
                    if ($urandom_range(0, 1) == 0) begin
                        amp = -amp - (amp == 32767 ? 1 : 0);
                    end
                    for (j = NUM_TAPS - 1; j >= 0; j--) begin
                        if (LOWPASS_TAPS[j] < 0) begin
                            pending_samples.push_back(
                                fir67_pkg::sample_t'(-amp - (amp == -32768 ? 1 : 0)));
                        end else begin
                            pending_samples.push_back(fir67_pkg::sample_t'(amp));
                        end
                    end
                end
                3, 4, 5: begin
                    run_len = $urandom_range(1, 40);
                    for (j = 0; j < run_len; j++) begin
                        pending_samples.push_back(
                            fir67_pkg::sample_t'($urandom_range(0, 65535)));
                    end
                end
                6: begin
                    run_len = $urandom_range(1, 30);
                    for (j = 0; j < run_len; j++) begin
                        pending_samples.push_back(($urandom_range(0, 1) == 0) ?
                                                  16'sd32767 : -16'sd32768);
                    end
                end
                7: begin
                    run_len = $urandom_range(1, 40);
                    for (j = 0; j < run_len; j++) begin
                        pending_samples.push_back(
                            fir67_pkg::sample_t'($urandom_range(0, 16)) - 16'sd8);
                    end
                end
                8: begin
                    level = fir67_pkg::sample_t'($urandom_range(0, 65535));
                    for (j = 0; j < NUM_TAPS; j++) begin
                        pending_samples.push_back(level);
                    end
                end
                default: begin
                    pending_samples.push_back(
                        fir67_pkg::sample_t'($urandom_range(0, 65535)));
                    run_len = $urandom_range(1, 70);
                    for (j = 0; j < run_len; j++) begin
                        pending_samples.push_back(16'sd0);
                    end
                end
            endcase
        end
        run_len = pending_samples.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every sample to be taken and every filter output to arrive,
        // then give the core time to show any output it should not produce.
        while (accepted_count != run_len || expected_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
